/* rtl/czps_pkg.sv */
package czps_pkg;

    localparam int CZPS_MAX_WIDTH   = 1024;
    localparam int CZPS_PIXEL_BITS  = 8;
    localparam int CZPS_KERNEL      = 3;
    localparam int CZPS_COEF_BITS   = 16;
    localparam int CZPS_ROW_BITS    = CZPS_KERNEL * CZPS_COEF_BITS;
    localparam int CZPS_WIDTH_BITS  = 11;
    localparam int CZPS_HEIGHT_BITS = 16;
    localparam int CZPS_VALUE_BITS  = 16;
    localparam int CZPS_INDEX_BITS  = 3;
    localparam int CZPS_FRAC_SHIFT  = 4;

    localparam logic [CZPS_ROW_BITS-1:0]    COEF_TOP_RESET = '0;
    localparam logic [CZPS_ROW_BITS-1:0]    COEF_MID_RESET = 48'h0000_1000_0000;
    localparam logic [CZPS_ROW_BITS-1:0]    COEF_BOT_RESET = '0;
    localparam logic [CZPS_WIDTH_BITS-1:0]  WIDTH_RESET    = 11'd1024;
    localparam logic [CZPS_HEIGHT_BITS-1:0] HEIGHT_RESET   = 16'd1024;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [CZPS_INDEX_BITS-1:0] {
        CFG_COEF_TOP = 3'd0,
        CFG_COEF_MID = 3'd1,
        CFG_COEF_BOT = 3'd2,
        CFG_WIDTH    = 3'd3,
        CFG_HEIGHT   = 3'd4
    } czps_cfg_index_t;

    typedef struct packed {
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
        logic last;
    } czps_mask_t;

endpackage

/* rtl/czps_line_buf.sv */
module czps_line_buf
    import czps_pkg::*;
#(
    parameter int DEPTH = CZPS_MAX_WIDTH,
    parameter int DW    = 2 * CZPS_PIXEL_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] mem_rd_reg;
    logic [DW-1:0] byp_data_reg;
    logic          byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_rd_reg   <= mem[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : mem_rd_reg;

endmodule

/* rtl/czps_mac.sv */
module czps_mac
    import czps_pkg::*;
#(
    parameter int PIXEL_BITS = CZPS_PIXEL_BITS,
    localparam int PW        = PIXEL_BITS + CZPS_COEF_BITS,
    localparam int SW        = PW + 2
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         ce,
    input  logic                                         in_res,
    input  czps_mask_t                                   in_mask,
    input  logic [CZPS_KERNEL-1:0][CZPS_KERNEL-1:0][PIXEL_BITS-1:0] window,
    input  logic [CZPS_KERNEL-1:0][CZPS_ROW_BITS-1:0]   coef_rows,
    output logic                                         out_res,
    output logic                                         out_last,
    output logic [CZPS_KERNEL-1:0][SW-1:0]              row_sum
);

    logic [CZPS_KERNEL-1:0][CZPS_KERNEL-1:0][PW-1:0] prod_next;
    logic [CZPS_KERNEL-1:0][CZPS_KERNEL-1:0][PW-1:0] prod_reg;
    logic [CZPS_KERNEL-1:0][SW-1:0]                  row_sum_next;
    logic [CZPS_KERNEL-1:0][SW-1:0]                  row_sum_reg;
    logic [CZPS_KERNEL-1:0]                          row_ok;
    logic [CZPS_KERNEL-1:0]                          col_ok;
    logic                                            res3_reg;
    logic                                            res4_reg;
    logic                                            last3_reg;
    logic                                            last4_reg;

    assign row_ok = {in_mask.row_bot, 1'b1, in_mask.row_top};
    assign col_ok = {in_mask.col_right, 1'b1, in_mask.col_left};

    always_comb begin
        for (int r = 0; r < CZPS_KERNEL; r++) begin
            for (int c = 0; c < CZPS_KERNEL; c++) begin
                if (row_ok[r] && col_ok[c]) begin
                    prod_next[r][c] = PW'(window[r][c])
                                    * PW'(coef_rows[r][c*CZPS_COEF_BITS +: CZPS_COEF_BITS]);
                end else begin
                    prod_next[r][c] = '0;
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < CZPS_KERNEL; r++) begin
            row_sum_next[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                            + SW'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res3_reg <= 1'b0;
            res4_reg <= 1'b0;
        end else if (ce) begin
            res3_reg <= in_res;
            res4_reg <= res3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg    <= prod_next;
            last3_reg   <= in_mask.last;
            row_sum_reg <= row_sum_next;
            last4_reg   <= last3_reg;
        end
    end

    assign out_res  = res4_reg;
    assign out_last = last4_reg;
    assign row_sum  = row_sum_reg;

endmodule

/* rtl/conv3x3_zero_pad_smoother_top.sv */
// 3x3 zero-padded convolution over a raster pixel stream.
// s_ channel: one transfer per pixel; s_tdata carries the pixel, s_tuser the
// item kind (pixel or flush tick; a flush tick acts as a zero pixel).
// m_ channel: one transfer per output pixel; m_tdata is the Q8.8 result
// (truncated, saturated at 0xFFFF), m_tlast marks the last pixel of a frame.
// cfg_we/cfg_index/cfg_wdata write the three Q4.12 kernel rows, the image
// width and the image height; write them only while the stream is idle.
// An output pixel exists once the pixel one row and one column past its
// center has been transferred; after a frame, send width+1 flush ticks.
// Throughput: one item per cycle while the output is not stalled. The result
// of an item reaches m_tdata through the line buffer read, window, products,
// row sums and output register.
// Reset: identity kernel, width and height 1024, position counters cleared,
// pipeline empty. Line buffer contents are undefined until written; no
// clearing pass is run.
// Stall: s_tready drops in the cycle the output register holds a result that
// m_tready does not take; the whole pipeline then holds.
module conv3x3_zero_pad_smoother_top
    import czps_pkg::*;
#(
    parameter int MAX_WIDTH   = CZPS_MAX_WIDTH,
    parameter int PIXEL_BITS  = CZPS_PIXEL_BITS,
    localparam int S_DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_DATA_BITS-1:0]      s_tdata,   // pixel
    input  logic                        s_tuser,   // op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [CZPS_VALUE_BITS-1:0]  m_tdata,   // value
    output logic                        m_tlast,   // frame_end
    input  logic                        cfg_we,
    input  logic [CZPS_INDEX_BITS-1:0]  cfg_index,
    input  logic [CZPS_ROW_BITS-1:0]    cfg_wdata
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = AW + 1;
    localparam int EW = (CW > CZPS_WIDTH_BITS) ? CW : CZPS_WIDTH_BITS;
    localparam int HW = CZPS_HEIGHT_BITS;
    localparam int PW = PIXEL_BITS + CZPS_COEF_BITS;
    localparam int SW = PW + 2;
    localparam int TW = SW + 2;
    localparam int VW = CZPS_VALUE_BITS;

    logic [CZPS_ROW_BITS-1:0]   coef_top_reg;
    logic [CZPS_ROW_BITS-1:0]   coef_mid_reg;
    logic [CZPS_ROW_BITS-1:0]   coef_bot_reg;
    logic [CZPS_WIDTH_BITS-1:0] width_reg;
    logic [HW-1:0]              height_reg;

    logic [EW-1:0] width_ext;
    logic [CW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    logic [AW-1:0] in_col_reg,  in_col_next;
    logic [HW-1:0] in_row_reg,  in_row_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;

    logic       pipe_adv;
    logic       s_accept;
    logic       in_col_wrap;
    logic       out_col_wrap;
    logic       out_row_last;
    logic       row_bot_ok;
    logic       valid_now;
    logic       last_now;
    czps_mask_t mask_now;
    logic [PIXEL_BITS-1:0] pix_now;

    logic                  s1_item_reg;
    logic                  s1_res_reg;
    czps_mask_t            s1_mask_reg;
    logic [AW-1:0]         s1_x_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [2*PIXEL_BITS-1:0] lb_rd_data;
    logic [2*PIXEL_BITS-1:0] lb_wr_data;

    logic [CZPS_KERNEL-1:0][CZPS_KERNEL-1:0][PIXEL_BITS-1:0] window_reg;
    logic       s2_res_reg;
    czps_mask_t s2_mask_reg;

    logic                           s4_res;
    logic                           s4_last;
    logic [CZPS_KERNEL-1:0][SW-1:0] row_sum;
    logic [TW-1:0]                  total;
    logic [TW-CZPS_FRAC_SHIFT-1:0]  shifted;
    logic [VW-1:0]                  value_sat;

    logic           m_tvalid_reg;
    logic [VW-1:0]  m_tdata_reg;
    logic           m_tlast_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= COEF_TOP_RESET;
            coef_mid_reg <= COEF_MID_RESET;
            coef_bot_reg <= COEF_BOT_RESET;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COEF_TOP: coef_top_reg <= cfg_wdata;
                CFG_COEF_MID: coef_mid_reg <= cfg_wdata;
                CFG_COEF_BOT: coef_bot_reg <= cfg_wdata;
                CFG_WIDTH:    width_reg    <= cfg_wdata[CZPS_WIDTH_BITS-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_wdata[HW-1:0];
                default: ;
            endcase
        end
    end

    assign width_ext = EW'(width_reg);

    always_comb begin
        if (width_reg == '0) begin
            eff_w = CW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(width_ext);
        end
    end

    assign eff_h = (height_reg == '0) ? HW'(1) : height_reg;

    assign pipe_adv = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_adv;
    assign s_accept = s_tvalid && pipe_adv;

    assign in_col_wrap  = ({1'b0, in_col_reg} + CW'(1)) >= eff_w;
    assign out_col_wrap = ({1'b0, out_col_reg} + CW'(1)) >= eff_w;
    assign out_row_last = ({1'b0, out_row_reg} + (HW+1)'(1)) >= {1'b0, eff_h};
    assign row_bot_ok   = !out_row_last;
    assign valid_now    = (in_row_reg >= HW'(2))
                       || ((in_row_reg == HW'(1)) && (in_col_reg != '0));
    assign last_now     = valid_now && out_col_wrap && out_row_last;
    assign pix_now      = (s_tuser == OP_FLUSH) ? '0 : s_tdata[PIXEL_BITS-1:0];

    assign mask_now.row_top   = out_row_reg != '0;
    assign mask_now.row_bot   = row_bot_ok;
    assign mask_now.col_left  = out_col_reg != '0;
    assign mask_now.col_right = !out_col_wrap;
    assign mask_now.last      = last_now;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s_accept) begin
            if (in_col_wrap) begin
                in_col_next = '0;
                if (in_row_reg != '1) begin
                    in_row_next = in_row_reg + HW'(1);
                end
            end else begin
                in_col_next = in_col_reg + AW'(1);
            end
            if (valid_now) begin
                if (out_col_wrap) begin
                    out_col_next = '0;
                    if (out_row_reg != '1) begin
                        out_row_next = out_row_reg + HW'(1);
                    end
                end else begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
            if (last_now) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_item_reg  <= 1'b0;
            s1_res_reg   <= 1'b0;
            s2_res_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            window_reg   <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (pipe_adv) begin
                s1_item_reg  <= s_tvalid;
                s1_res_reg   <= s_tvalid && valid_now;
                s2_res_reg   <= s1_res_reg;
                m_tvalid_reg <= s4_res;
                if (s1_item_reg) begin
                    for (int r = 0; r < CZPS_KERNEL; r++) begin
                        window_reg[r][0] <= window_reg[r][1];
                        window_reg[r][1] <= window_reg[r][2];
                    end
                    window_reg[0][2] <= lb_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
                    window_reg[1][2] <= lb_rd_data[PIXEL_BITS-1:0];
                    window_reg[2][2] <= s1_pix_reg;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_mask_reg <= mask_now;
            s1_x_reg    <= in_col_reg;
            s1_pix_reg  <= pix_now;
        end
        if (pipe_adv) begin
            s2_mask_reg <= s1_mask_reg;
            m_tdata_reg <= value_sat;
            m_tlast_reg <= s4_last;
        end
    end

    assign lb_wr_data = {lb_rd_data[PIXEL_BITS-1:0], s1_pix_reg};

    czps_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * PIXEL_BITS)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (in_col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (pipe_adv && s1_item_reg),
        .wr_addr (s1_x_reg),
        .wr_data (lb_wr_data)
    );

    czps_mac #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (pipe_adv),
        .in_res    (s2_res_reg),
        .in_mask   (s2_mask_reg),
        .window    (window_reg),
        .coef_rows ({coef_bot_reg, coef_mid_reg, coef_top_reg}),
        .out_res   (s4_res),
        .out_last  (s4_last),
        .row_sum   (row_sum)
    );

    assign total     = TW'(row_sum[0]) + TW'(row_sum[1]) + TW'(row_sum[2]);
    assign shifted   = total[TW-1:CZPS_FRAC_SHIFT];
    assign value_sat = (|shifted[TW-CZPS_FRAC_SHIFT-1:VW]) ? '1 : shifted[VW-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && last_now |=> in_col_reg == '0 && in_row_reg == '0
                                 && out_col_reg == '0 && out_row_reg == '0)
        else $error("frame end did not clear position counters");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s4_res))
        else $error("result raised without an item in the last stage");

endmodule
